>>> rtl/postfix_stack_evaluator_macros.svh
// Assertion macros shared by the postfix stack evaluator RTL.
// Include this header by its bare name; it needs nothing else.
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// Assert a property on an explicit clock, held off while reset is high
`define PSE_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert a property on the block's own clock and reset
`define PSE_ASSERT(label, prop, msg) \
   `PSE_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

>>> rtl/pse_pkg.sv
// Package for the postfix stack evaluator: sizes, codes, transaction types.
// No dependencies; every RTL file of the block imports it.
package pse_pkg;

   localparam int STACK_DEPTH   = 64;
   localparam int VALUE_WIDTH   = 32;
   localparam int ADDR_W        = $clog2(STACK_DEPTH);
   localparam int COUNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ITER_W        = $clog2(VALUE_WIDTH);
   localparam int OP_W          = 3;
   localparam int FIELD_VALUE_W = 32;
   localparam int FIELD_DEPTH_W = 7;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [ITER_W-1:0]      iter_type;

   // Token operation codes; codes above OP_DIV are ignored
   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_DIV0  = 2'd2,
      ST_OVER  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_OPER,
      SEQ_WAIT,
      SEQ_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_MUL,
      ALU_DIV,
      ALU_DONE
   } alu_state_type;

   typedef struct packed {
      logic [OP_W-1:0]                 operation;
      logic signed [FIELD_VALUE_W-1:0] operand_value;
      logic                            end_of_expression;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_VALUE_W-1:0] top_value;
      logic                            expression_done;
      status_type                      status;
      logic [FIELD_DEPTH_W-1:0]        stack_depth;
   } rsp_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      value_type data;
   } ram_wr_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
   } ram_rd_type;

   typedef struct packed {
      logic            start;
      logic [OP_W-1:0] op;
      value_type       a;
      value_type       b;
   } alu_req_type;

   // True for the four binary operators
   function automatic logic is_arith(input logic [OP_W-1:0] op);
      return (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
   endfunction

endpackage

>>> rtl/postfix_stack_evaluator.sv
// Postfix expression evaluator: one token per req transaction, one rsp
// transaction per token.
// req: operation, operand_value, end_of_expression. An operand is pushed; an
// operator pops right then left operand and pushes add/sub/mul/div of them.
// rsp: top_value, expression_done, status (first fault wins), stack_depth.
// Push and ignored codes go straight to the finish step; add/subtract,
// multiply and divide go through the shared ALU, one multiply or divide
// bit per cycle, and a divide by zero skips the ALU.
// The rsp transaction appears in the same cycle that req_stall drops again.
// One token is in flight at a time; req_stall is high while it is worked on.
// A finished rsp waits in an output register; if rsp_stall holds it, the
// next token can still be taken and worked on, and its result waits in the
// sequencer until the output register frees up.
// Reset empties the stack at once (count only, no clearing pass) and drops
// any pending rsp. Stack entries are undefined until pushed.
// Depends on pse_pkg, pse_stack_ram, pse_alu.
`include "postfix_stack_evaluator_macros.svh"

module postfix_stack_evaluator
   import pse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   seq_state_type   state_ff, state_in;
   logic [OP_W-1:0] op_ff;
   value_type       opnd_ff;
   logic            eoe_ff;
   status_type      st_ff;
   count_type       cnt_ff;
   value_type       top_ff;
   value_type       res_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic        req_take, rsp_free, rsp_load;
   ram_wr_type  ram_wr;
   ram_rd_type  ram_rd;
   value_type   ram_rd_data;
   alu_req_type alu_req;
   logic        alu_done;
   value_type   alu_result;

   value_type   oper_a, oper_b;
   status_type  oper_st;
   count_type   oper_cnt;
   logic        div_zero;

   logic        fin_push, fin_full;
   value_type   fin_val, fin_top, top_out;
   status_type  fin_st;
   count_type   fin_cnt;

   pse_stack_ram u_ram (
      .clock   (clock),
      .ram_wr  (ram_wr),
      .ram_rd  (ram_rd),
      .rd_data (ram_rd_data)
   );

   pse_alu u_alu (
      .clock      (clock),
      .reset      (reset),
      .alu_req    (alu_req),
      .alu_done   (alu_done),
      .alu_result (alu_result)
   );

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Pop both operands; left one comes from the RAM read issued at acceptance
   always_comb begin
      oper_b   = (cnt_ff != '0) ? top_ff : '0;
      oper_a   = (cnt_ff > count_type'(1)) ? ram_rd_data : '0;
      oper_st  = (cnt_ff > count_type'(1)) ? ST_OK : ST_UNDER;
      oper_cnt = (cnt_ff > count_type'(1)) ? (cnt_ff - count_type'(2)) : '0;
      div_zero = (op_ff == OP_DIV) && (oper_b == '0);
   end

   // Push the result, then handle the end-of-expression pop
   always_comb begin
      fin_push = (op_ff == OP_PUSH) || is_arith(op_ff);
      fin_val  = (op_ff == OP_PUSH) ? opnd_ff : res_ff;
      fin_full = (cnt_ff >= count_type'(STACK_DEPTH));
      fin_st   = st_ff;
      fin_cnt  = cnt_ff;
      fin_top  = top_ff;
      if (fin_push) begin
         if (fin_full) begin
            if (fin_st == ST_OK) begin
               fin_st = ST_OVER;
            end
         end else begin
            fin_cnt = cnt_ff + 1'b1;
            fin_top = fin_val;
         end
      end
      top_out = (fin_cnt != '0) ? fin_top : '0;
      if (eoe_ff) begin
         if ((fin_cnt == '0) && (fin_st == ST_OK)) begin
            fin_st = ST_UNDER;
         end
         fin_cnt = '0;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_take) begin
               state_in = is_arith(req_payload.operation) ? SEQ_OPER : SEQ_FINISH;
            end
         end
         SEQ_OPER:   state_in = div_zero ? SEQ_FINISH : SEQ_WAIT;
         SEQ_WAIT:   state_in = alu_done ? SEQ_FINISH : SEQ_WAIT;
         SEQ_FINISH: state_in = rsp_free ? SEQ_IDLE : SEQ_FINISH;
         default:    state_in = SEQ_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, RAM ports, ALU start
   always_comb begin
      req_stall     = (state_ff != SEQ_IDLE);
      rsp_load      = (state_ff == SEQ_FINISH) && rsp_free;
      ram_rd.en     = req_take;
      ram_rd.addr   = addr_type'(cnt_ff - count_type'(2));
      ram_wr.en     = rsp_load && fin_push && !fin_full;
      ram_wr.addr   = addr_type'(cnt_ff);
      ram_wr.data   = fin_val;
      alu_req.start = (state_ff == SEQ_OPER) && !div_zero;
      alu_req.op    = op_ff;
      alu_req.a     = oper_a;
      alu_req.b     = oper_b;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == SEQ_OPER) begin
            cnt_ff <= oper_cnt;
         end else if (rsp_load) begin
            cnt_ff <= fin_cnt;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Token, operand and result registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_payload.operation;
         opnd_ff <= value_type'(req_payload.operand_value);
         eoe_ff  <= req_payload.end_of_expression;
         st_ff   <= ST_OK;
      end else if (state_ff == SEQ_OPER) begin
         st_ff <= (div_zero && (oper_st == ST_OK)) ? ST_DIV0 : oper_st;
         if (div_zero) begin
            res_ff <= '0;
         end
      end
      if (alu_done) begin
         res_ff <= alu_result;
      end
      if (rsp_load) begin
         top_ff                 <= fin_top;
         rsp_ff.top_value       <= FIELD_VALUE_W'(top_out);
         rsp_ff.expression_done <= eoe_ff;
         rsp_ff.status          <= fin_st;
         rsp_ff.stack_depth     <= FIELD_DEPTH_W'(fin_cnt);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `PSE_ASSERT(a_cnt_bound, cnt_ff <= count_type'(STACK_DEPTH), "stack count beyond depth")
   `PSE_ASSERT(a_done_empty, rsp_valid && rsp_payload.expression_done |-> rsp_payload.stack_depth == '0, "stack not empty at expression end")
   `PSE_ASSERT(a_alu_in_wait, alu_done |-> state_ff == SEQ_WAIT, "ALU result outside wait state")
   `PSE_ASSERT(a_over_push, rsp_load && fin_st == ST_OVER |-> op_ff == OP_PUSH, "overflow on a non-push token")
   `PSE_ASSERT(a_take_busy, req_valid && !req_stall |=> state_ff != SEQ_IDLE, "accepted token left sequencer idle")

endmodule

>>> rtl/pse_stack_ram.sv
// Operand stack storage: one write port, one read port with registered data.
// Depends on pse_pkg for depth and value width.
module pse_stack_ram
   import pse_pkg::*;
(
   input  logic       clock,
   input  ram_wr_type ram_wr,
   input  ram_rd_type ram_rd,
   output value_type  rd_data
);

   value_type mem [STACK_DEPTH];
   value_type rd_data_ff;

   // Write and read the stack array
   always_ff @(posedge clock) begin
      if (ram_wr.en) begin
         mem[ram_wr.addr] <= ram_wr.data;
      end
      if (ram_rd.en) begin
         rd_data_ff <= mem[ram_rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pse_alu.sv
// Shared arithmetic unit: add/subtract, shift-add multiply and
// restoring signed divide, one bit per cycle. Depends on pse_pkg.
`include "postfix_stack_evaluator_macros.svh"

module pse_alu
   import pse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type alu_req,
   output logic        alu_done,
   output value_type   alu_result
);

   alu_state_type        state_ff, state_in;
   logic [OP_W-1:0]      op_ff;
   logic                 neg_ff;
   value_type            acc_ff;
   value_type            opa_ff;
   value_type            opb_ff;
   logic [VALUE_WIDTH:0] rem_ff;
   iter_type             iter_ff;

   logic                 last_iter;
   value_type            mag_a, mag_b;
   logic [VALUE_WIDTH:0] rem_shift, rem_trial;

   // Magnitudes for the divider and one restoring step
   always_comb begin
      mag_a     = alu_req.a[VALUE_WIDTH-1] ? (~alu_req.a + 1'b1) : alu_req.a;
      mag_b     = alu_req.b[VALUE_WIDTH-1] ? (~alu_req.b + 1'b1) : alu_req.b;
      rem_shift = {rem_ff[VALUE_WIDTH-1:0], acc_ff[VALUE_WIDTH-1]};
      rem_trial = rem_shift - {1'b0, opb_ff};
      last_iter = (iter_ff == iter_type'(VALUE_WIDTH - 1));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ALU_IDLE: begin
            if (alu_req.start) begin
               unique case (alu_req.op)
                  OP_MUL:  state_in = ALU_MUL;
                  OP_DIV:  state_in = ALU_DIV;
                  default: state_in = ALU_DONE;
               endcase
            end
         end
         ALU_MUL, ALU_DIV: begin
            if (last_iter) begin
               state_in = ALU_DONE;
            end
         end
         ALU_DONE: state_in = ALU_IDLE;
         default:  state_in = ALU_IDLE;
      endcase
   end

   // Outputs: apply the quotient sign on the way out
   always_comb begin
      alu_done   = (state_ff == ALU_DONE);
      alu_result = ((op_ff == OP_DIV) && neg_ff) ? (~acc_ff + 1'b1) : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Load operands, then advance one multiply or divide bit per cycle
   always_ff @(posedge clock) begin
      if ((state_ff == ALU_IDLE) && alu_req.start) begin
         op_ff   <= alu_req.op;
         iter_ff <= '0;
         neg_ff  <= alu_req.a[VALUE_WIDTH-1] ^ alu_req.b[VALUE_WIDTH-1];
         rem_ff  <= '0;
         case (alu_req.op)
            OP_ADD: acc_ff <= alu_req.a + alu_req.b;
            OP_SUB: acc_ff <= alu_req.a - alu_req.b;
            OP_MUL: begin
               acc_ff <= '0;
               opa_ff <= alu_req.a;
               opb_ff <= alu_req.b;
            end
            default: begin
               acc_ff <= mag_a;
               opb_ff <= mag_b;
            end
         endcase
      end else if (state_ff == ALU_MUL) begin
         if (opb_ff[0]) begin
            acc_ff <= acc_ff + opa_ff;
         end
         opa_ff  <= opa_ff << 1;
         opb_ff  <= opb_ff >> 1;
         iter_ff <= iter_ff + 1'b1;
      end else if (state_ff == ALU_DIV) begin
         if (!rem_trial[VALUE_WIDTH]) begin
            rem_ff <= rem_trial;
         end else begin
            rem_ff <= rem_shift;
         end
         acc_ff  <= {acc_ff[VALUE_WIDTH-2:0], ~rem_trial[VALUE_WIDTH]};
         iter_ff <= iter_ff + 1'b1;
      end
   end

   `PSE_ASSERT(a_start_idle, alu_req.start |-> state_ff == ALU_IDLE, "ALU started while busy")
   `PSE_ASSERT(a_rem_below_div, state_ff == ALU_DIV |-> rem_ff < {1'b0, opb_ff}, "remainder not below divisor")
   `PSE_ASSERT(a_done_pulse, state_ff == ALU_DONE |=> state_ff == ALU_IDLE, "ALU result held past one cycle")

endmodule
